/* hdl/ptwc_pkg.sv */
// Shared types, constants and codes for the peak-triggered window capture block.
package ptwc_pkg;

  // Field and register widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned PosW     = 6;
  localparam int unsigned ThrW     = 15;
  localparam int unsigned RatioW   = 8;
  localparam int unsigned CfgDataW = 15;

  // Parameter defaults
  localparam int unsigned RingDepthDef  = 64;
  localparam int unsigned HalfWindowDef = 15;

  // Register reset values
  localparam logic [ThrW-1:0]   ThrReset   = 15'd4096;
  localparam logic [RatioW-1:0] RatioReset = 8'd128;

  // Register indexes on the configuration port
  typedef enum logic [0:0] {
    CfgPeakThreshold = 1'b0,
    CfgDropRatio     = 1'b1
  } ptwc_cfg_idx_e;

  // One input sample
  typedef struct packed {
    logic signed [SampleW-1:0] accel_x;
    logic signed [SampleW-1:0] accel_y;
    logic signed [SampleW-1:0] accel_z;
  } ptwc_in_t;

  // One window result
  typedef struct packed {
    logic signed [SampleW-1:0] win_x;
    logic signed [SampleW-1:0] win_y;
    logic signed [SampleW-1:0] win_z;
    logic [PosW-1:0]           position;
    logic                      last;
  } ptwc_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_step;
    logic take;
    logic eval;
    logic emit_step;
  } ptwc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic trigger;
    logic emit_last;
    logic out_free;
  } ptwc_sts_t;

endpackage

/* hdl/peak_triggered_window_capture_top.sv */
// Top level of the peak-triggered window capture block.
// Each transfer on the input channel is one (x, y, z) sample written into a ring of RingDepth
// entries. Once |x| passes the peak threshold the block tracks the x peak; when x drops below
// it by more than drop_ratio/256 of the peak, the block sends 2*HalfWindow+1 results centred on
// the peak, then restarts the ring at the trigger sample. A sample that does not trigger goes
// through a ring write, then a peak evaluation. A triggering sample adds one ring memory read
// per result through its single read port, and the output side can stall each result. After
// reset the block zeroes all RingDepth ring memory entries, one entry per cycle, with
// in_ready_o low; configuration writes are taken throughout.
module peak_triggered_window_capture_top import ptwc_pkg::*; #(
  parameter int unsigned RingDepth  = RingDepthDef,
  parameter int unsigned HalfWindow = HalfWindowDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptwc_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptwc_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  ptwc_cfg_idx_e       cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  ptwc_cmd_t cmd;
  ptwc_sts_t sts;

  // Sequence the work
  ptwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Store samples, track the peak and read out windows
  ptwc_datapath #(
    .RingDepth  (RingDepth),
    .HalfWindow (HalfWindow)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

/* hdl/ptwc_datapath.sv */
// Datapath: sample ring memory, peak tracking, trigger compare and window readout.
module ptwc_datapath import ptwc_pkg::*; #(
  parameter int unsigned RingDepth  = RingDepthDef,
  parameter int unsigned HalfWindow = HalfWindowDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptwc_cmd_t           cmd_i,
  output ptwc_sts_t           sts_o,
  input  ptwc_in_t            in_data_i,
  input  logic                cfg_we_i,
  input  ptwc_cfg_idx_e       cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output ptwc_out_t           out_data_o
);

  localparam int unsigned PtrW = $clog2(RingDepth);
  localparam int unsigned OffW = ((PtrW > PosW) ? PtrW : PosW) + 2;
  localparam logic [PtrW-1:0]        PtrMax  = PtrW'(RingDepth - 1);
  localparam logic [PtrW:0]          RingExt = (PtrW + 1)'(RingDepth);
  localparam logic signed [OffW-1:0] RingOff = OffW'(RingDepth);
  localparam logic signed [OffW-1:0] HalfOff = OffW'(HalfWindow);
  localparam logic [PosW-1:0]        LastPos = PosW'(2 * HalfWindow);

  // Configuration registers
  logic [ThrW-1:0]   thr_q;
  logic [RatioW-1:0] ratio_q;

  // Ring state and tracking
  logic [PtrW-1:0]    newest_q, newest_d;
  logic [PtrW-1:0]    oldest_q, oldest_d;
  logic [PtrW-1:0]    peak_ptr_q, peak_ptr_d;
  logic [SampleW-1:0] peak_q, peak_d;
  logic               armed_q, armed_d;
  logic [SampleW-1:0] mag_q;
  logic [PtrW-1:0]    clr_q;

  // Window snapshot
  logic [PtrW-1:0] base_q;
  logic [PtrW-1:0] lspan_q;
  logic [PtrW-1:0] rspan_q;
  logic [PosW-1:0] pos_q;

  // Output register
  logic      out_valid_q;
  ptwc_in_t  rd_q;
  logic [PosW-1:0] opos_q;
  logic      olast_q;

  ptwc_in_t ring_mem [RingDepth];

  logic [PtrW-1:0]    newest_inc;
  logic [SampleW-1:0] mag;
  logic               armed_n;
  logic               upd;
  logic               trig;
  logic [SampleW-1:0] diff;
  logic [23:0]        drop_lhs;
  logic [23:0]        drop_rhs;
  logic [PtrW-1:0]    lspan_w;
  logic [PtrW-1:0]    rspan_w;
  logic               mem_we;
  logic [PtrW-1:0]    mem_waddr;
  ptwc_in_t           mem_wdata;
  logic signed [OffW-1:0] off_raw;
  logic signed [OffW-1:0] off_cl;
  logic signed [OffW-1:0] lneg;
  logic signed [OffW-1:0] rpos;
  logic signed [OffW-1:0] slot_raw;
  logic signed [OffW-1:0] slot_fix;
  logic [PtrW-1:0]    rd_slot;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ThrReset;
      ratio_q <= RatioReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPeakThreshold: thr_q   <= cfg_wdata_i[ThrW-1:0];
        CfgDropRatio:     ratio_q <= cfg_wdata_i[RatioW-1:0];
        default: ;
      endcase
    end
  end

  // Advance write pointer and take magnitude of X
  always_comb begin
    newest_inc = (newest_q == PtrMax) ? '0 : newest_q + 1'b1;
    mag = in_data_i.accel_x[SampleW-1] ? SampleW'(-in_data_i.accel_x)
                                       : SampleW'(in_data_i.accel_x);
  end

  // Evaluate arming, peak update and drop trigger
  always_comb begin
    armed_n  = armed_q | (mag_q > SampleW'(thr_q));
    upd      = armed_n && (mag_q > peak_q);
    diff     = peak_q - mag_q;
    drop_lhs = {diff, 8'h00};
    drop_rhs = 24'(ratio_q) * 24'(peak_q);
    trig     = !upd && (peak_q > SampleW'(thr_q)) &&
               ((mag_q > peak_q) || (drop_lhs > drop_rhs));
    // Wrap pointer distances back into the ring
    lspan_w  = (peak_ptr_q >= oldest_q) ? peak_ptr_q - oldest_q
             : PtrW'({1'b0, peak_ptr_q} + RingExt - {1'b0, oldest_q});
    rspan_w  = (newest_q >= peak_ptr_q) ? newest_q - peak_ptr_q
             : PtrW'({1'b0, newest_q} + RingExt - {1'b0, peak_ptr_q});
  end

  // Next values of ring pointers and tracking state
  always_comb begin
    newest_d   = newest_q;
    oldest_d   = oldest_q;
    peak_d     = peak_q;
    peak_ptr_d = peak_ptr_q;
    armed_d    = armed_q;
    if (cmd_i.take) begin
      newest_d = newest_inc;
      if (newest_inc == oldest_q) begin
        oldest_d = (oldest_q == PtrMax) ? '0 : oldest_q + 1'b1;
      end
    end
    if (cmd_i.eval) begin
      armed_d = armed_n;
      if (upd) begin
        peak_d     = mag_q;
        peak_ptr_d = newest_q;
      end else if (trig) begin
        oldest_d   = newest_q;
        armed_d    = 1'b0;
        peak_d     = '0;
        peak_ptr_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q   <= '0;
      oldest_q   <= '0;
      peak_q     <= '0;
      peak_ptr_q <= '0;
      armed_q    <= 1'b0;
    end else begin
      newest_q   <= newest_d;
      oldest_q   <= oldest_d;
      peak_q     <= peak_d;
      peak_ptr_q <= peak_ptr_d;
      armed_q    <= armed_d;
    end
  end

  // Hold sample magnitude and window snapshot
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mag_q <= mag;
    end
    if (cmd_i.eval && trig) begin
      base_q  <= peak_ptr_q;
      lspan_q <= lspan_w;
      rspan_q <= rspan_w;
    end
  end

  // Clearing pass address and window position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      pos_q <= '0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q <= (clr_q == PtrMax) ? '0 : clr_q + 1'b1;
      end
      if (cmd_i.emit_step) begin
        pos_q <= (pos_q == LastPos) ? '0 : pos_q + 1'b1;
      end
    end
  end

  // Select ring write: zero fill during clearing pass, else the new sample
  always_comb begin
    mem_we    = cmd_i.clear_step | cmd_i.take;
    mem_waddr = cmd_i.clear_step ? clr_q : newest_inc;
    mem_wdata = cmd_i.clear_step ? '0 : in_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Clamp window offset to stored span and wrap to a ring slot
  always_comb begin
    off_raw = $signed(OffW'(pos_q)) - HalfOff;
    lneg    = -$signed(OffW'(lspan_q));
    rpos    = $signed(OffW'(rspan_q));
    off_cl  = off_raw;
    if (off_cl < lneg) begin
      off_cl = lneg;
    end
    if (off_cl > rpos) begin
      off_cl = rpos;
    end
    slot_raw = $signed(OffW'(base_q)) + off_cl;
    if (slot_raw < 0) begin
      slot_fix = slot_raw + RingOff;
    end else if (slot_raw >= RingOff) begin
      slot_fix = slot_raw - RingOff;
    end else begin
      slot_fix = slot_raw;
    end
    rd_slot = slot_fix[PtrW-1:0];
  end

  // Read ring into the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      rd_q    <= ring_mem[rd_slot];
      opos_q  <= pos_q;
      olast_q <= (pos_q == LastPos);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    out_data_o.win_x    = rd_q.accel_x;
    out_data_o.win_y    = rd_q.accel_y;
    out_data_o.win_z    = rd_q.accel_z;
    out_data_o.position = opos_q;
    out_data_o.last     = olast_q;
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.clear_done = (clr_q == PtrMax);
    sts_o.trigger    = trig;
    sts_o.emit_last  = (pos_q == LastPos);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

`ifndef NO_ASSERTIONS
  // A trigger restarts the ring at the trigger sample
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && trig) |=> (oldest_q == newest_q && !armed_q && peak_q == '0))
    else $error("ring not restarted after trigger");

  // A stored sample never leaves the ring empty
  a_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |=> (oldest_q != newest_q))
    else $error("ring empty after sample write");

  // A tracked peak implies armed
  a_peak_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (peak_q != '0) |-> armed_q)
    else $error("peak tracked while not armed");

  // The last window result carries the final position
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && olast_q) |-> (opos_q == LastPos))
    else $error("last flag on wrong position");
`endif

endmodule

/* hdl/ptwc_ctrl.sv */
// Controller: sequences clearing pass, sample intake, evaluation and window readout.
module ptwc_ctrl import ptwc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ptwc_sts_t sts_i,
  output ptwc_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StEval  = 4'b0100,
    StEmit  = 4'b1000
  } ptwc_state_e;

  ptwc_state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = StEval;
        end
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.trigger ? StEmit : StIdle;
      end
      StEmit: begin
        cmd_o.emit_step = sts_i.out_free;
        if (sts_i.out_free && sts_i.emit_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

endmodule

/* bench/ptwc_window_checker.sv */
// Checker for the peak-triggered window capture block: predicts every window and compares it.
`timescale 1ns / 1ps
module ptwc_window_checker import ptwc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ptwc_in_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ptwc_out_t           out_data_i,
  input  logic                cfg_we_i,
  input  ptwc_cfg_idx_e       cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  mismatches_o,
  output int                  beats_due_o,
  output int                  samples_o,
  output int                  windows_o,
  output int                  beats_o
);

  localparam int Depth = RingDepthDef;
  localparam int Half  = HalfWindowDef;
  localparam int Span  = 2 * Half + 1;

  // Private copy of the sample ring, pointers, peak tracker and registers
  ptwc_in_t          ring_copy [Depth];
  int                head_slot;
  int                tail_slot;
  int                crest_slot;
  int unsigned       crest_mag;
  bit                tracking;
  logic [ThrW-1:0]   arm_level;
  logic [RatioW-1:0] fall_frac;

  // Window samples predicted but not yet seen on the output channel
  ptwc_out_t         pending_beats_q [$];

  int mismatch_cnt;
  int sample_cnt;
  int window_cnt;
  int beat_cnt;

  // Print one line per mismatch and count it
  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // Store one sample, update the peak tracker and queue the window it triggers
  task automatic predict_window(input ptwc_in_t s);
    logic [SampleW-1:0] raw_x;
    int unsigned        mag;
    int unsigned        fall;
    longint unsigned    drop_scaled;
    longint unsigned    limit_scaled;
    int                 lspan;
    int                 rspan;
    int                 d;
    int                 slot;
    int                 p;
    ptwc_out_t          beat;
    head_slot = (head_slot + 1) % Depth;
    if (head_slot == tail_slot) begin
      tail_slot = (tail_slot + 1) % Depth;
    end
    ring_copy[head_slot] = s;

    // |x| with the most negative value taken as 32768
    raw_x = s.accel_x;
    mag = raw_x[SampleW-1] ? 32'h10000 - raw_x : raw_x;
    if (mag > arm_level) begin
      tracking = 1'b1;
    end

    fall = crest_mag - mag;
    drop_scaled = fall;
    drop_scaled = drop_scaled * 256;
    limit_scaled = fall_frac;
    limit_scaled = limit_scaled * crest_mag;

    if (tracking && mag > crest_mag) begin
      crest_mag = mag;
      crest_slot = head_slot;
    end else if (crest_mag > arm_level && drop_scaled > limit_scaled) begin
      // Read the window around the peak, clamping at both ends of the stored span
      lspan = (crest_slot - tail_slot + Depth) % Depth;
      rspan = (head_slot - crest_slot + Depth) % Depth;
      for (p = 0; p < Span; p++) begin
        d = p - Half;
        if (d < -lspan) begin
          d = -lspan;
        end
        if (d > rspan) begin
          d = rspan;
        end
        slot = (crest_slot + d + Depth) % Depth;
        beat.win_x    = ring_copy[slot].accel_x;
        beat.win_y    = ring_copy[slot].accel_y;
        beat.win_z    = ring_copy[slot].accel_z;
        beat.position = p[PosW-1:0];
        beat.last     = (p == Span - 1);
        pending_beats_q.push_back(beat);
      end
      // Restart the ring at the trigger sample and drop the peak
      tail_slot = head_slot;
      tracking = 1'b0;
      crest_mag = 0;
      crest_slot = 0;
      window_cnt++;
    end
  endtask

  // Compare one window sample against the oldest prediction
  task automatic check_beat(input ptwc_out_t got);
    ptwc_out_t want;
    if (pending_beats_q.size() == 0) begin
      note_mismatch($sformatf("window sample with none expected: x=%0d pos=%0d last=%0b",
                              got.win_x, got.position, got.last));
    end else begin
      want = pending_beats_q.pop_front();
      if (got.win_x !== want.win_x) begin
        note_mismatch($sformatf("beat %0d pos %0d: win_x %0d, expected %0d",
                                beat_cnt, want.position, got.win_x, want.win_x));
      end
      if (got.win_y !== want.win_y) begin
        note_mismatch($sformatf("beat %0d pos %0d: win_y %0d, expected %0d",
                                beat_cnt, want.position, got.win_y, want.win_y));
      end
      if (got.win_z !== want.win_z) begin
        note_mismatch($sformatf("beat %0d pos %0d: win_z %0d, expected %0d",
                                beat_cnt, want.position, got.win_z, want.win_z));
      end
      if (got.position !== want.position) begin
        note_mismatch($sformatf("beat %0d: position %0d, expected %0d",
                                beat_cnt, got.position, want.position));
      end
      if (got.last !== want.last) begin
        note_mismatch($sformatf("beat %0d pos %0d: last %0b, expected %0b",
                                beat_cnt, want.position, got.last, want.last));
      end
      beat_cnt++;
    end
  endtask

  // Watch register writes and both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    int i;
    if (!rst_ni) begin
      for (i = 0; i < Depth; i++) begin
        ring_copy[i] = '0;
      end
      head_slot = 0;
      tail_slot = 0;
      crest_slot = 0;
      crest_mag = 0;
      tracking = 1'b0;
      arm_level = ThrReset;
      fall_frac = RatioReset;
      pending_beats_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPeakThreshold: arm_level = cfg_wdata_i[ThrW-1:0];
          CfgDropRatio:     fall_frac = cfg_wdata_i[RatioW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        check_beat(out_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        sample_cnt++;
        predict_window(in_data_i);
      end
    end
    mismatches_o <= mismatch_cnt;
    beats_due_o  <= pending_beats_q.size();
    samples_o    <= sample_cnt;
    windows_o    <= window_cnt;
    beats_o      <= beat_cnt;
  end

endmodule

/* bench/peak_triggered_window_capture_top_test.sv */
// Testbench top for the peak-triggered window capture block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module peak_triggered_window_capture_top_test;
  import ptwc_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned PhaseItems    = 80;
  localparam int unsigned RandomPhases  = 6;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  ptwc_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ptwc_out_t           out_data;
  logic                cfg_we    = 1'b0;
  ptwc_cfg_idx_e       cfg_idx   = CfgPeakThreshold;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int mismatches;
  int beats_due;
  int samples;
  int windows;
  int beats;

  int unsigned thr_now;
  int unsigned ratio_now;
  int unsigned sent;
  int unsigned burst_left;
  int unsigned settings;
  int unsigned idle_cycles = 0;

  // Toggle the clock every half period
  always #5 clk_i = ~clk_i;

  peak_triggered_window_capture_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  ptwc_window_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .beats_due_o  (beats_due),
    .samples_o    (samples),
    .windows_o    (windows),
    .beats_o      (beats)
  );

  function automatic ptwc_in_t make_sample(input int x, input int y, input int z);
    ptwc_in_t s;
    s.accel_x = 16'(x);
    s.accel_y = 16'(y);
    s.accel_z = 16'(z);
    return s;
  endfunction

  // Build a sample whose |x| is mag, with a random sign and random y, z
  function automatic ptwc_in_t shape_sample(input int unsigned mag);
    ptwc_in_t    s;
    logic [16:0] m;
    m = mag[16:0];
    if (mag == 32768 || (mag != 0 && $urandom_range(0, 1) == 1)) begin
      s.accel_x = 16'(17'h10000 - m);
    end else begin
      s.accel_x = m[15:0];
    end
    s.accel_y = 16'($urandom);
    s.accel_z = 16'($urandom);
    return s;
  endfunction

  // Offer one sample in bursts with random gaps; return after its transfer
  task automatic offer_sample(input ptwc_in_t s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_data  <= s;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  // Hold the input until every predicted window sample is out, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write both registers; junk goes into the unused upper bits of the ratio word
  task automatic program_regs(input int unsigned thr, input int unsigned ratio);
    logic [CfgDataW-1:0] word;
    word = CfgDataW'($urandom);
    word[RatioW-1:0] = ratio[RatioW-1:0];
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgPeakThreshold;
    cfg_wdata <= thr[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_idx   <= CfgDropRatio;
    cfg_wdata <= word;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    thr_now   = thr;
    ratio_now = ratio;
    settings++;
  endtask

  // Quiet lead-in, rise to a peak, plateau that must not trigger, then a triggering drop
  task automatic play_event();
    int unsigned quiet_n;
    int unsigned rise_n;
    int unsigned flat_n;
    int unsigned peak;
    int unsigned lim;
    int unsigned k;
    quiet_n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 20);
    for (k = 0; k < quiet_n; k++) begin
      offer_sample(shape_sample($urandom_range(0, thr_now)));
    end
    peak = $urandom_range(thr_now + 1, 32768);
    rise_n = $urandom_range(1, 6);
    for (k = 1; k <= rise_n; k++) begin
      offer_sample(shape_sample(thr_now + 1 + (peak - thr_now - 1) * k / rise_n));
    end
    // Largest |x| that still counts as a drop past the ratio
    lim = (256 * peak - ratio_now * peak - 1) / 256;
    flat_n = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 90) : $urandom_range(0, 4);
    for (k = 0; k < flat_n; k++) begin
      offer_sample(shape_sample($urandom_range(lim + 1, peak)));
    end
    offer_sample(shape_sample($urandom_range(0, lim)));
  endtask

  // Fully random samples
  task automatic play_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    repeat (n) offer_sample(make_sample($urandom, $urandom, $urandom));
  endtask

  // Stall the output side on a pattern of its own, with one long hold-off now and then
  initial begin : receiver
    int unsigned stretch;
    int unsigned mode;
    int unsigned held;
    int          hold_mark;
    hold_mark = -1;
    forever begin
      stretch = $urandom_range(8, 160);
      mode = $urandom_range(0, 2);
      repeat (stretch) begin
        @(posedge clk_i);
        if (windows != hold_mark && (windows == 6 || windows == 20)) begin
          hold_mark = windows;
          held = 0;
          out_ready <= 1'b0;
          while (held < HoldOffCycles) begin
            @(posedge clk_i);
            held++;
          end
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("peak_triggered_window_capture_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    sent = 0;
    burst_left = 0;
    settings = 1;
    thr_now = ThrReset;
    ratio_now = RatioReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zeroed slot as oldest sample, most negative x, drop exactly at the ratio
    offer_sample(make_sample(0, 0, 0));
    offer_sample(make_sample(32767, -32768, 32767));
    offer_sample(make_sample(-32767, 1, -1));
    offer_sample(make_sample(100, 32767, -32768));
    offer_sample(make_sample(4096, -1, 0));
    offer_sample(make_sample(4097, 12345, -12345));
    offer_sample(make_sample(-32768, -32768, -32768));
    offer_sample(make_sample(16384, 0, 32767));
    offer_sample(make_sample(16383, -2, 2));

    // Top threshold and ratio: only the most negative x arms
    settle();
    program_regs(32767, 255);
    offer_sample(make_sample(32767, 5, -5));
    offer_sample(make_sample(-32768, 32767, 0));
    offer_sample(make_sample(-32767, -32768, 1));
    offer_sample(make_sample(128, 7, 7));
    offer_sample(make_sample(127, -7, -7));

    // Zero threshold and ratio: any nonzero x arms, any fall triggers
    settle();
    program_regs(0, 0);
    offer_sample(make_sample(1, 100, -100));
    offer_sample(make_sample(-1, -100, 100));
    offer_sample(make_sample(0, 32767, 32767));
    offer_sample(make_sample(0, -32768, -32768));

    // Random phases, each under its own register setting
    for (phase = 0; phase < RandomPhases; phase++) begin
      settle();
      case (phase)
        1:       program_regs(0, 0);
        3:       program_regs(32767, 255);
        5:       program_regs(ThrReset, RatioReset);
        default: program_regs($urandom_range(1, 32766), $urandom_range(1, 254));
      endcase
      while (sent < 18 + PhaseItems * (phase + 1)) begin
        if ($urandom_range(0, 4) == 0) begin
          play_noise();
        end else begin
          play_event();
        end
      end
    end

    // Drain and let the block finish its last evaluation
    settle();
    repeat (32) @(posedge clk_i);

    $display("Run covered %0d samples and %0d windows (%0d window samples) under %0d settings,",
             samples, windows, beats, settings);
    $display("with a %0d-cycle output hold-off, ring wrap-around and clamped window edges.",
             HoldOffCycles);
    if (mismatches == 0 && beats_due == 0) begin
      $display("peak_triggered_window_capture_top verification clean");
    end else begin
      $display("%0d mismatches, %0d window samples never arrived", mismatches, beats_due);
      $display("peak_triggered_window_capture_top verification failed");
    end
    $finish;
  end

endmodule

/* peak_triggered_window_capture_top.f */
hdl/ptwc_pkg.sv
hdl/ptwc_datapath.sv
hdl/ptwc_ctrl.sv
hdl/peak_triggered_window_capture_top.sv
bench/ptwc_window_checker.sv
bench/peak_triggered_window_capture_top_test.sv
